// ----- src/ihex_pkg.sv -----
// ihex_pkg: types, constants and helper functions for the intel hex record encoder
// used by ihex_front, ihex_queue, ihex_back and intel_hex_record_encoder
// no dependencies
`default_nettype none

package ihex_pkg;

	localparam logic [5:0]  MAX_RECORD_BYTES = 6'd32;
	localparam logic [16:0] BLOCK_BYTES      = 17'h10000;

	localparam logic [7:0] CH_COLON          = 8'h3A;
	localparam logic [7:0] CH_NL             = 8'h0A;
	localparam logic [7:0] CH_ZERO           = 8'h30;
	localparam logic [7:0] CH_HEX_ALPHA_BASE = 8'h37;

	localparam logic [7:0] REC_DATA  = 8'h00;
	localparam logic [7:0] REC_EOF   = 8'h01;
	localparam logic [7:0] REC_ELA   = 8'h04;
	localparam logic [7:0] ELA_COUNT = 8'h02;
	localparam logic [7:0] EOF_CSUM  = 8'hFF;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	localparam logic [3:0] ELA_LAST_POS   = 4'd15;
	localparam logic [3:0] HDR_LAST_POS   = 4'd8;
	localparam logic [3:0] DATA_LAST_POS  = 4'd1;
	localparam logic [3:0] CLOSE_LAST_POS = 4'd2;
	localparam logic [3:0] EOF_LAST_POS   = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELA,
		ST_HDR,
		ST_DATA,
		ST_CLOSE,
		ST_EOF
	} ihex_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_image;
	} ihex_in_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       run_last;
	} ihex_out_t;

	typedef struct packed {
		logic        ela;
		logic        hdr;
		logic        close;
		logic        eof;
		logic [15:0] blk;
		logic [7:0]  ela_csum;
		logic [15:0] offset;
		logic [5:0]  len;
		logic [7:0]  data;
		logic [7:0]  csum;
	} ihex_cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10)
			r = CH_ZERO + {4'd0, n};
		else
			r = CH_HEX_ALPHA_BASE + {4'd0, n};
		return r;
	endfunction

	function automatic logic [5:0] eff_len(input logic [5:0] v);
		logic [5:0] c;
		logic [5:0] p;
		c = (v > MAX_RECORD_BYTES) ? MAX_RECORD_BYTES : v;
		p = 6'd1;
		for (int i = 0; i < 6; i++) begin
			if (c[i])
				p = 6'd1 << i;
		end
		return p;
	endfunction

	function automatic logic [7:0] twos(input logic [7:0] s);
		return ~s + 8'd1;
	endfunction

endpackage

`default_nettype wire

// ----- src/ihex_front.sv -----
// ihex_front: accepts image bytes, tracks address and record state, builds one command per byte
// holds the record length register
// depends on ihex_pkg
`default_nettype none

module ihex_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ihex_pkg::ihex_in_t in_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [5:0]        cfg_data,
	input  wire logic              q_full,
	output logic                   push,
	output ihex_pkg::ihex_cmd_t    push_cmd
);

	logic [5:0]  record_bytes_q;
	logic [15:0] block_number_q;
	logic [15:0] block_offset_q;
	logic [5:0]  record_position_q;
	logic [7:0]  running_sum_q;

	logic [5:0]  len;
	logic        pos0;
	logic [7:0]  base_sum;
	logic [7:0]  sum_new;
	logic [5:0]  pos_new;
	logic        full;
	logic [16:0] off_sum;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;

	always_comb begin
		len      = ihex_pkg::eff_len(record_bytes_q);
		pos0     = (record_position_q == 6'd0);
		base_sum = pos0 ? ({2'b00, len} + block_offset_q[15:8] + block_offset_q[7:0])
				: running_sum_q;
		sum_new  = base_sum + in_data.data_byte;
		pos_new  = record_position_q + 6'd1;
		full     = (pos_new >= len);
		off_sum  = {1'b0, block_offset_q} + {11'd0, len};

		push_cmd.ela      = pos0 && (block_offset_q == 16'd0);
		push_cmd.hdr      = pos0;
		push_cmd.close    = full || in_data.end_of_image;
		push_cmd.eof      = in_data.end_of_image;
		push_cmd.blk      = block_number_q;
		push_cmd.ela_csum = ihex_pkg::twos(ihex_pkg::ELA_COUNT + ihex_pkg::REC_ELA
				+ block_number_q[15:8] + block_number_q[7:0]);
		push_cmd.offset   = block_offset_q;
		push_cmd.len      = len;
		push_cmd.data     = in_data.data_byte;
		push_cmd.csum     = ihex_pkg::twos(sum_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_bytes_q <= ihex_pkg::MAX_RECORD_BYTES;
		end else if (cfg_valid) begin
			record_bytes_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_number_q    <= '0;
			block_offset_q    <= '0;
			record_position_q <= '0;
			running_sum_q     <= '0;
		end else if (push) begin
			if (in_data.end_of_image) begin
				block_number_q    <= '0;
				block_offset_q    <= '0;
				record_position_q <= '0;
				running_sum_q     <= '0;
			end else if (full) begin
				record_position_q <= '0;
				running_sum_q     <= '0;
				if (off_sum >= ihex_pkg::BLOCK_BYTES) begin
					block_offset_q <= '0;
					block_number_q <= block_number_q + 16'd1;
				end else begin
					block_offset_q <= off_sum[15:0];
				end
			end else begin
				record_position_q <= pos_new;
				running_sum_q     <= sum_new;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/ihex_queue.sv -----
// ihex_queue: small command queue between the front and back parts
// depends on ihex_pkg
`default_nettype none

module ihex_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire ihex_pkg::ihex_cmd_t push_cmd,
	output logic                     full,
	input  wire logic                pop,
	output logic                     head_valid,
	output ihex_pkg::ihex_cmd_t      head_cmd
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	ihex_pkg::ihex_cmd_t entry_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/ihex_back.sv -----
// ihex_back: character sequencer that turns queued commands into hex text
// one character per cycle into an output register, unless out stalls or the queue is empty
// depends on ihex_pkg
`default_nettype none

module ihex_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire ihex_pkg::ihex_cmd_t head_cmd,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ihex_pkg::ihex_out_t      out_data
);

	ihex_pkg::ihex_state_t state_q;
	ihex_pkg::ihex_state_t state_d;
	ihex_pkg::ihex_state_t cur;
	ihex_pkg::ihex_state_t nxt;
	logic [3:0] pos_q;
	logic [3:0] pos_d;
	logic [3:0] k;
	logic [3:0] last_pos;
	logic       active;
	logic       emit;
	logic       hi_nib;
	logic [7:0] sel_byte;
	logic [7:0] ch;
	logic       at_end;
	logic       out_valid_q;
	ihex_pkg::ihex_out_t out_data_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihex_pkg::ST_IDLE;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

	always_comb begin
		if (state_q != ihex_pkg::ST_IDLE)
			cur = state_q;
		else if (head_cmd.ela)
			cur = ihex_pkg::ST_ELA;
		else if (head_cmd.hdr)
			cur = ihex_pkg::ST_HDR;
		else
			cur = ihex_pkg::ST_DATA;

		active   = head_valid;
		emit     = active && (!out_valid_q || !out_stall);
		k        = pos_q - 4'd1;
		hi_nib   = !k[0];
		sel_byte = ihex_pkg::ZERO_BYTE;
		ch       = ihex_pkg::CH_NL;
		last_pos = ihex_pkg::DATA_LAST_POS;
		nxt      = ihex_pkg::ST_IDLE;

		case (cur)
			ihex_pkg::ST_ELA: begin
				last_pos = ihex_pkg::ELA_LAST_POS;
				nxt      = ihex_pkg::ST_HDR;
				case (k[3:1])
					3'd0: sel_byte = ihex_pkg::ELA_COUNT;
					3'd3: sel_byte = ihex_pkg::REC_ELA;
					3'd4: sel_byte = head_cmd.blk[15:8];
					3'd5: sel_byte = head_cmd.blk[7:0];
					3'd6: sel_byte = head_cmd.ela_csum;
					default: sel_byte = ihex_pkg::ZERO_BYTE;
				endcase
			end
			ihex_pkg::ST_HDR: begin
				last_pos = ihex_pkg::HDR_LAST_POS;
				nxt      = ihex_pkg::ST_DATA;
				case (k[3:1])
					3'd0: sel_byte = {2'b00, head_cmd.len};
					3'd1: sel_byte = head_cmd.offset[15:8];
					3'd2: sel_byte = head_cmd.offset[7:0];
					default: sel_byte = ihex_pkg::REC_DATA;
				endcase
			end
			ihex_pkg::ST_DATA: begin
				last_pos = ihex_pkg::DATA_LAST_POS;
				sel_byte = head_cmd.data;
				hi_nib   = (pos_q == 4'd0);
				if (head_cmd.close)
					nxt = ihex_pkg::ST_CLOSE;
				else if (head_cmd.eof)
					nxt = ihex_pkg::ST_EOF;
				else
					nxt = ihex_pkg::ST_IDLE;
			end
			ihex_pkg::ST_CLOSE: begin
				last_pos = ihex_pkg::CLOSE_LAST_POS;
				sel_byte = head_cmd.csum;
				hi_nib   = (pos_q == 4'd0);
				nxt      = head_cmd.eof ? ihex_pkg::ST_EOF : ihex_pkg::ST_IDLE;
			end
			ihex_pkg::ST_EOF: begin
				last_pos = ihex_pkg::EOF_LAST_POS;
				nxt      = ihex_pkg::ST_IDLE;
				case (k[3:1])
					3'd3: sel_byte = ihex_pkg::REC_EOF;
					3'd4: sel_byte = ihex_pkg::EOF_CSUM;
					default: sel_byte = ihex_pkg::ZERO_BYTE;
				endcase
			end
			default: begin
				last_pos = ihex_pkg::DATA_LAST_POS;
				nxt      = ihex_pkg::ST_IDLE;
			end
		endcase

		at_end = (pos_q == last_pos);

		if ((cur == ihex_pkg::ST_DATA) || ((cur == ihex_pkg::ST_CLOSE) && !at_end)
				|| ((pos_q != 4'd0) && !(at_end && cur != ihex_pkg::ST_HDR)))
			ch = ihex_pkg::hex_char(hi_nib ? sel_byte[7:4] : sel_byte[3:0]);
		else if (pos_q == 4'd0)
			ch = ihex_pkg::CH_COLON;
		else
			ch = ihex_pkg::CH_NL;

		state_d = state_q;
		pos_d   = pos_q;
		pop     = 1'b0;
		if (emit) begin
			if (at_end) begin
				state_d = nxt;
				pos_d   = '0;
				pop     = (nxt == ihex_pkg::ST_IDLE);
			end else begin
				state_d = cur;
				pos_d   = pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.text_char <= ch;
			out_data_q.run_last  <= at_end && (nxt == ihex_pkg::ST_IDLE);
		end
	end

endmodule

`default_nettype wire

// ----- src/intel_hex_record_encoder.sv -----
// intel_hex_record_encoder: binary image bytes in, intel hex text out, 32-bit linear addressing
// top level; instantiates ihex_front, ihex_queue and ihex_back; depends on ihex_pkg
//
//   channel  signals                         payload
//   in       in_valid / in_stall             data_byte, end_of_image
//   out      out_valid / out_stall           text_char, run_last
//   cfg      cfg_valid / cfg_ready           record_bytes (6 bits)
//
// one text character per cycle unless out stalls or the queue is empty; a byte costs 2 characters,
// plus 9 on opening a record, 16 on opening a 64 KiB block, 3 on closing a record and 12 for the
// end-of-file record (about 2.4 characters per byte at 32-byte records); the sequencer sets the rate
// the front takes a request per cycle while the command queue has room
// reset clears all address and record state; record_bytes resets to 32
// a stall on out holds the output register; the sequencer and queue wait behind it
`default_nettype none

module intel_hex_record_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ihex_pkg::ihex_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ihex_pkg::ihex_out_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [5:0]          cfg_data
);

	logic                q_full;
	logic                push;
	ihex_pkg::ihex_cmd_t push_cmd;
	logic                pop;
	logic                head_valid;
	ihex_pkg::ihex_cmd_t head_cmd;

	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	ihex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	ihex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire
